/* rtl/core/dsm_pkg.sv */
`timescale 1ns / 1ps

package dsm_pkg;

   localparam int MAX_SLOTS    = 512;
   localparam int MAX_GROUPING = 63;
   localparam int MAX_PIXELS   = 16384;

   localparam int SLOT_W  = 10;
   localparam int INDEX_W = 14;
   localparam int COPY_W  = 6;
   localparam int GROUP_W = 8;
   localparam int LEVEL_W = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNELS_PER_PIXEL  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_ORDER         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUP_COUNT         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUPING_COUNT      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ADDRESS       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_OFFSET_ENABLE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLACKOUT            = 3'd6;

   localparam logic [2:0] ORDER_RGB = 3'd0;
   localparam logic [2:0] ORDER_RBG = 3'd1;
   localparam logic [2:0] ORDER_GRB = 3'd2;
   localparam logic [2:0] ORDER_GBR = 3'd3;
   localparam logic [2:0] ORDER_BRG = 3'd4;
   localparam logic [2:0] ORDER_BGR = 3'd5;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_LATCH = 1'b1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } rgb_type;

   // One queued job: an optional run of pixel writes and an optional latch.
   typedef struct packed {
      logic               pixels;
      logic [COPY_W-1:0]  copies;
      logic [INDEX_W-1:0] base;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] white;
      logic               latch;
   } cmd_type;

   function automatic rgb_type color_select(input logic [2:0] order,
                                            input logic [LEVEL_W-1:0] d0,
                                            input logic [LEVEL_W-1:0] d1,
                                            input logic [LEVEL_W-1:0] d2);
      rgb_type c;
      case (order)
         ORDER_RBG: c = '{red: d0, green: d2, blue: d1};
         ORDER_GRB: c = '{red: d1, green: d0, blue: d2};
         ORDER_GBR: c = '{red: d2, green: d0, blue: d1};
         ORDER_BRG: c = '{red: d1, green: d2, blue: d0};
         ORDER_BGR: c = '{red: d2, green: d1, blue: d0};
         default:   c = '{red: d0, green: d1, blue: d2};
      endcase
      return c;
   endfunction

endpackage

/* rtl/core/dsm_fifo.sv */
`timescale 1ns / 1ps

module dsm_fifo
   import dsm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    not_empty,
   output logic    full
);

   cmd_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/dsm_front.sv */
`timescale 1ns / 1ps

module dsm_front
   import dsm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [LEVEL_W-1:0]     slot_value,
   input  logic                   first_slot,
   input  logic                   last_slot,
   input  logic                   do_update,
   input  logic                   driver_busy,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   push,
   output cmd_type                cmd
);

   logic [2:0]          cpp_ff, order_ff;
   logic [GROUP_W-1:0]  group_count_ff;
   logic [COPY_W-1:0]   grouping_ff;
   logic [SLOT_W-1:0]   start_ff;
   logic                offset_en_ff, blackout_ff;

   logic [SLOT_W-1:0]   pos_ff, pos_in;
   logic [1:0]          phase_ff, phase_in;
   logic [GROUP_W-1:0]  gp_ff, gp_in;
   logic                drop_ff, drop_in;
   logic [LEVEL_W-1:0]  hold_ff [3];
   logic [LEVEL_W-1:0]  hold_in [3];

   logic [SLOT_W-1:0]   pos_e, skip;
   logic [1:0]          phase_e;
   logic [GROUP_W-1:0]  gp_e;
   logic                drop_e, active, complete;
   logic [2:0]          cpp;
   rgb_type             rgb;

   always_comb begin
      pos_e   = first_slot ? '0 : pos_ff;
      phase_e = first_slot ? '0 : phase_ff;
      gp_e    = first_slot ? '0 : gp_ff;
      drop_e  = first_slot ? driver_busy : drop_ff;

      pos_in   = pos_e;
      phase_in = phase_e;
      gp_in    = gp_e;
      drop_in  = drop_e;
      hold_in  = hold_ff;
      complete = 1'b0;

      cpp  = (cpp_ff == 3'd4) ? 3'd4 : 3'd3;
      skip = '0;
      if (offset_en_ff && start_ff != '0) begin
         skip = start_ff - 1'b1;
      end
      active = !drop_e && (pos_e < SLOT_W'(MAX_SLOTS));

      if (active && pos_e >= skip && gp_e < group_count_ff) begin
         if ({1'b0, phase_e} + 3'd1 < cpp) begin
            case (phase_e)
               2'd0: hold_in[0] = slot_value;
               2'd1: hold_in[1] = slot_value;
               2'd2: hold_in[2] = slot_value;
               default: ;
            endcase
            phase_in = phase_e + 1'b1;
         end else begin
            complete = 1'b1;
            phase_in = '0;
            gp_in    = gp_e + 1'b1;
         end
      end
      if (active) begin
         pos_in = pos_e + 1'b1;
      end

      rgb = color_select(order_ff, hold_ff[0], hold_ff[1], slot_value);

      cmd.pixels = complete && (grouping_ff != '0);
      cmd.copies = grouping_ff;
      cmd.base   = INDEX_W'({{(INDEX_W-GROUP_W){1'b0}}, gp_e} *
                            {{(INDEX_W-COPY_W){1'b0}}, grouping_ff});
      if (cpp == 3'd4) begin
         cmd.red   = hold_ff[0];
         cmd.green = hold_ff[1];
         cmd.blue  = hold_ff[2];
         cmd.white = slot_value;
      end else begin
         cmd.red   = rgb.red;
         cmd.green = rgb.green;
         cmd.blue  = rgb.blue;
         cmd.white = '0;
      end
      cmd.latch = 1'b0;
      if (last_slot) begin
         cmd.latch = !drop_e && do_update && !blackout_ff;
         drop_in   = 1'b1;
      end

      push = accept && (cmd.pixels || cmd.latch);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= '0;
         gp_ff    <= '0;
         drop_ff  <= 1'b0;
         hold_ff  <= '{default: '0};
      end else if (accept) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         gp_ff    <= gp_in;
         drop_ff  <= drop_in;
         hold_ff  <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpp_ff         <= 3'd3;
         order_ff       <= ORDER_RGB;
         group_count_ff <= GROUP_W'(170);
         grouping_ff    <= COPY_W'(1);
         start_ff       <= SLOT_W'(1);
         offset_en_ff   <= 1'b1;
         blackout_ff    <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CHANNELS_PER_PIXEL:  cpp_ff         <= csr_data[2:0];
            CSR_COLOR_ORDER:         order_ff       <= csr_data[2:0];
            CSR_GROUP_COUNT:         group_count_ff <= csr_data[GROUP_W-1:0];
            CSR_GROUPING_COUNT:      grouping_ff    <= csr_data[COPY_W-1:0];
            CSR_START_ADDRESS:       start_ff       <= csr_data[SLOT_W-1:0];
            CSR_START_OFFSET_ENABLE: offset_en_ff   <= csr_data[0];
            CSR_BLACKOUT:            blackout_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

endmodule

/* rtl/core/dsm_back.sv */
`timescale 1ns / 1ps

module dsm_back
   import dsm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            head,
   input  logic               head_valid,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic [INDEX_W-1:0] rsp_pixel_index,
   output logic [LEVEL_W-1:0] rsp_red,
   output logic [LEVEL_W-1:0] rsp_green,
   output logic [LEVEL_W-1:0] rsp_blue,
   output logic [LEVEL_W-1:0] rsp_white,
   output logic               rsp_last
);

   cmd_type             cur_ff;
   logic [COPY_W-1:0]   k_ff, k_in;
   logic                pix_ff, pix_in;
   logic                latch_ff, latch_in;
   logic                busy, out_free, emit, last_copy;

   logic                valid_ff, valid_in;
   logic                kind_ff, kind_in, last_ff, last_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [LEVEL_W-1:0]  red_ff, red_in, green_ff, green_in;
   logic [LEVEL_W-1:0]  blue_ff, blue_in, white_ff, white_in;

   assign busy      = pix_ff || latch_ff;
   assign out_free  = !valid_ff || !rsp_stall;
   assign emit      = busy && out_free;
   assign pop       = !busy && head_valid;
   assign last_copy = ((k_ff + 1'b1) == cur_ff.copies);

   always_comb begin
      k_in     = k_ff;
      pix_in   = pix_ff;
      latch_in = latch_ff;
      valid_in = valid_ff && rsp_stall;
      kind_in  = kind_ff;
      index_in = index_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      white_in = white_ff;
      last_in  = last_ff;

      if (pop) begin
         k_in     = '0;
         pix_in   = head.pixels;
         latch_in = head.latch;
      end else if (emit) begin
         valid_in = 1'b1;
         if (pix_ff) begin
            kind_in  = KIND_PIXEL;
            index_in = cur_ff.base + {{(INDEX_W-COPY_W){1'b0}}, k_ff};
            red_in   = cur_ff.red;
            green_in = cur_ff.green;
            blue_in  = cur_ff.blue;
            white_in = cur_ff.white;
            last_in  = last_copy && !latch_ff;
            k_in     = k_ff + 1'b1;
            if (last_copy) begin
               pix_in = 1'b0;
            end
         end else begin
            kind_in  = KIND_LATCH;
            index_in = '0;
            red_in   = '0;
            green_in = '0;
            blue_in  = '0;
            white_in = '0;
            last_in  = 1'b1;
            latch_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff   <= 1'b0;
         latch_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pix_ff   <= pix_in;
         latch_ff <= latch_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
      k_ff     <= k_in;
      kind_ff  <= kind_in;
      index_ff <= index_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      white_ff <= white_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_pixel_index = index_ff;
   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = blue_ff;
   assign rsp_white       = white_ff;
   assign rsp_last        = last_ff;

endmodule

/* rtl/core/dmx_slot_to_pixel_mapper.sv */
`timescale 1ns / 1ps

// Maps the slots of a DMX frame onto pixel writes. The front end takes one slot beat per
// cycle, tracks the slot and group position, gathers three or four channels and queues one
// job per slot that finishes a group of nonzero grouping or asks for a latch in a four-entry
// queue; it stalls the slot side only when that queue is full. The back end expands each job
// into one pixel write per cycle while the output is not stalled, one for each copy of the
// group, then the latch item, through a registered output stage. It takes no new job until
// it is through with the last one, so the sustained rate is set by the grouping count;
// slots that only collect a channel queue no job. A slot's result passes through the queue,
// the back-end job register and the output stage. Configuration writes are always ready.
module dmx_slot_to_pixel_mapper
   import dsm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [LEVEL_W-1:0]     req_slot_value,
   input  logic                   req_first_slot,
   input  logic                   req_last_slot,
   input  logic                   req_do_update,
   input  logic                   req_driver_busy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_kind,
   output logic [INDEX_W-1:0]     rsp_pixel_index,
   output logic [LEVEL_W-1:0]     rsp_red,
   output logic [LEVEL_W-1:0]     rsp_green,
   output logic [LEVEL_W-1:0]     rsp_blue,
   output logic [LEVEL_W-1:0]     rsp_white,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic    accept, push, pop, not_empty, full;
   cmd_type cmd, head;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign csr_ready = 1'b1;

   dsm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .slot_value  (req_slot_value),
      .first_slot  (req_first_slot),
      .last_slot   (req_last_slot),
      .do_update   (req_do_update),
      .driver_busy (req_driver_busy),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .push        (push),
      .cmd         (cmd)
   );

   dsm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd),
      .pop       (pop),
      .pop_data  (head),
      .not_empty (not_empty),
      .full      (full)
   );

   dsm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_valid      (not_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_white       (rsp_white),
      .rsp_last        (rsp_last)
   );

endmodule

/* rtl/core/dsm_checker.sv */
`timescale 1ns / 1ps

module dsm_checker
   import dsm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_kind,
   input logic [INDEX_W-1:0] rsp_pixel_index,
   input logic [LEVEL_W-1:0] rsp_red,
   input logic [LEVEL_W-1:0] rsp_green,
   input logic [LEVEL_W-1:0] rsp_blue,
   input logic [LEVEL_W-1:0] rsp_white,
   input logic               rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_index) && $stable(rsp_kind))
      else $error("result beat changed while stalled");

   a_latch_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_LATCH |->
         rsp_last && rsp_pixel_index == '0 && rsp_red == '0 && rsp_green == '0 &&
         rsp_blue == '0 && rsp_white == '0)
      else $error("latch beat carries pixel data or is not last");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channel active right after reset");

   a_copy_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind == KIND_PIXEL && !rsp_last ##1
         rsp_valid && rsp_kind == KIND_PIXEL |->
         rsp_pixel_index == $past(rsp_pixel_index) + 1'b1)
      else $error("pixel copies of one group are not consecutive");

endmodule

bind dmx_slot_to_pixel_mapper dsm_checker u_dsm_checker (.*);

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
   import dsm_pkg::*;

   typedef struct {
      logic [LEVEL_W-1:0] value;
      bit                 first;
      bit                 last;
      bit                 upd;
      bit                 busy;
   } slot_beat_type;

   typedef struct {
      logic               kind;
      logic [INDEX_W-1:0] pixel_index;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] white;
      logic               last;
   } pixel_beat_type;

   class pixel_scoreboard;
      logic [2:0]         channels_reg;
      logic [2:0]         order_reg;
      logic [GROUP_W-1:0] groups_reg;
      logic [COPY_W-1:0]  grouping_reg;
      logic [SLOT_W-1:0]  start_reg;
      bit                 offset_on;
      bit                 blackout_on;

      logic [SLOT_W-1:0]  slot_pos;
      logic [1:0]         chan_phase;
      logic [LEVEL_W-1:0] chan_hold [3];
      logic [GROUP_W-1:0] group_pos;
      bit                 dropped;

      pixel_beat_type     expected_q [$];
      int                 errors;

      function new();
         channels_reg = 3;
         order_reg = ORDER_RGB;
         groups_reg = 170;
         grouping_reg = 1;
         start_reg = 1;
         offset_on = 1;
         blackout_on = 0;
         slot_pos = 0;
         chan_phase = 0;
         chan_hold = '{default: '0};
         group_pos = 0;
         dropped = 0;
         errors = 0;
      endfunction

      function void set_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_CHANNELS_PER_PIXEL:  channels_reg = val[2:0];
            CSR_COLOR_ORDER:         order_reg = val[2:0];
            CSR_GROUP_COUNT:         groups_reg = val[GROUP_W-1:0];
            CSR_GROUPING_COUNT:      grouping_reg = val[COPY_W-1:0];
            CSR_START_ADDRESS:       start_reg = val[SLOT_W-1:0];
            CSR_START_OFFSET_ENABLE: offset_on = val[0];
            CSR_BLACKOUT:            blackout_on = val[0];
            default: ;
         endcase
      endfunction

      function void note_slot(input slot_beat_type s);
         int unsigned        skip;
         int unsigned        copies;
         int unsigned        base;
         int unsigned        idx;
         bit                 four;
         logic [LEVEL_W-1:0] d0, d1, d2;
         pixel_beat_type     px;
         pixel_beat_type     burst [$];

         if (s.first) begin
            slot_pos = 0;
            chan_phase = 0;
            group_pos = 0;
            dropped = s.busy;
         end

         if (!dropped && slot_pos < MAX_SLOTS) begin
            skip = 0;
            if (offset_on)
               skip = (start_reg == 0) ? 0 : start_reg - 1;
            if (slot_pos >= skip && group_pos < groups_reg) begin
               four = (channels_reg == 4);
               if (chan_phase + 1 < (four ? 4 : 3)) begin
                  chan_hold[chan_phase] = s.value;
                  chan_phase = chan_phase + 2'd1;
               end else begin
                  px.kind = KIND_PIXEL;
                  px.last = 0;
                  d0 = chan_hold[0];
                  d1 = chan_hold[1];
                  d2 = s.value;
                  if (four) begin
                     px.red = d0;
                     px.green = d1;
                     px.blue = chan_hold[2];
                     px.white = s.value;
                  end else begin
                     px.white = 0;
                     case (order_reg)
                        ORDER_RBG: begin
                           px.red = d0; px.green = d2; px.blue = d1;
                        end
                        ORDER_GRB: begin
                           px.red = d1; px.green = d0; px.blue = d2;
                        end
                        ORDER_GBR: begin
                           px.red = d2; px.green = d0; px.blue = d1;
                        end
                        ORDER_BRG: begin
                           px.red = d1; px.green = d2; px.blue = d0;
                        end
                        ORDER_BGR: begin
                           px.red = d2; px.green = d1; px.blue = d0;
                        end
                        default: begin
                           px.red = d0; px.green = d1; px.blue = d2;
                        end
                     endcase
                  end
                  copies = (grouping_reg > MAX_GROUPING) ? MAX_GROUPING : grouping_reg;
                  base = group_pos * grouping_reg;
                  for (int unsigned k = 0; k < copies; k++) begin
                     idx = base + k;
                     if (idx < MAX_PIXELS) begin
                        px.pixel_index = idx[INDEX_W-1:0];
                        burst.push_back(px);
                     end
                  end
                  chan_phase = 0;
                  group_pos = group_pos + 1'b1;
               end
            end
            slot_pos = slot_pos + 1'b1;
         end

         if (s.last) begin
            if (!dropped && s.upd && !blackout_on) begin
               px = '{kind: KIND_LATCH, pixel_index: 0, red: 0, green: 0, blue: 0,
                      white: 0, last: 0};
               burst.push_back(px);
            end
            dropped = 1;
         end

         if (burst.size() > 0)
            burst[burst.size() - 1].last = 1;
         foreach (burst[i])
            expected_q.push_back(burst[i]);
      endfunction

      function void check_result(input pixel_beat_type got);
         pixel_beat_type want;

         if (expected_q.size() == 0) begin
            $error("unexpected result beat: kind %0d, pixel_index %0d", got.kind,
                   got.pixel_index);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            errors++;
         end
         if (got.pixel_index !== want.pixel_index) begin
            $error("pixel_index: expected %0d, actual %0d", want.pixel_index,
                   got.pixel_index);
            errors++;
         end
         if (got.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, got.red);
            errors++;
         end
         if (got.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, got.green);
            errors++;
         end
         if (got.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, got.blue);
            errors++;
         end
         if (got.white !== want.white) begin
            $error("white: expected %0d, actual %0d", want.white, got.white);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [LEVEL_W-1:0]     req_slot_value;
   logic                   req_first_slot;
   logic                   req_last_slot;
   logic                   req_do_update;
   logic                   req_driver_busy;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_kind;
   logic [INDEX_W-1:0]     rsp_pixel_index;
   logic [LEVEL_W-1:0]     rsp_red;
   logic [LEVEL_W-1:0]     rsp_green;
   logic [LEVEL_W-1:0]     rsp_blue;
   logic [LEVEL_W-1:0]     rsp_white;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   bit calm = 0;
   int hold_left = 0;

   pixel_scoreboard book = new();

   dmx_slot_to_pixel_mapper DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_slot_value  (req_slot_value),
      .req_first_slot  (req_first_slot),
      .req_last_slot   (req_last_slot),
      .req_do_update   (req_do_update),
      .req_driver_busy (req_driver_busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_white       (rsp_white),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #2 clock = ~clock;

   function automatic slot_beat_type beat(input logic [LEVEL_W-1:0] v, input bit f,
                                          input bit l, input bit u, input bit b);
      slot_beat_type s;

      s.value = v;
      s.first = f;
      s.last = l;
      s.upd = u;
      s.busy = b;
      return s;
   endfunction

   task automatic send_slot(input slot_beat_type s);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_slot_value = s.value;
      req_first_slot = s.first;
      req_last_slot = s.last;
      req_do_update = s.upd;
      req_driver_busy = s.busy;
      do @(posedge clock); while (req_stall);
      book.note_slot(s);
      @(negedge clock);
   endtask

   task automatic send_frame(input int len, input bit busy, input bit upd, input bit head,
                             input bit tail);
      slot_beat_type s;

      for (int i = 0; i < len; i++) begin
         s.value = LEVEL_W'($urandom_range(0, 255));
         s.first = head && (i == 0);
         s.last = tail && (i == len - 1);
         s.upd = s.last ? upd : 1'($urandom_range(0, 1));
         s.busy = s.first ? busy : 1'($urandom_range(0, 1));
         send_slot(s);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      book.set_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (book.expected_q.size() != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic apply_setup(input int channels, input int order, input int groups,
                              input int grouping, input int start, input int offset_en,
                              input int blackout_en);
      drain();
      write_reg(CSR_CHANNELS_PER_PIXEL, CSR_DATA_W'(channels));
      write_reg(CSR_COLOR_ORDER, CSR_DATA_W'(order));
      write_reg(CSR_GROUP_COUNT, CSR_DATA_W'(groups));
      write_reg(CSR_GROUPING_COUNT, CSR_DATA_W'(grouping));
      write_reg(CSR_START_ADDRESS, CSR_DATA_W'(start));
      write_reg(CSR_START_OFFSET_ENABLE, CSR_DATA_W'(offset_en));
      write_reg(CSR_BLACKOUT, CSR_DATA_W'(blackout_en));
   endtask

   task automatic random_setup();
      int channels;
      int groups;
      int grouping;
      int start;
      int pick;

      channels = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                             : ($urandom_range(0, 1) ? 4 : 3);
      pick = $urandom_range(0, 9);
      groups = (pick == 0) ? $urandom_range(0, 255) : (pick == 1) ? 170
                                                    : $urandom_range(1, 16);
      pick = $urandom_range(0, 9);
      grouping = (pick == 0) ? $urandom_range(0, 63) : (pick == 1) ? 63
                                                     : $urandom_range(1, 3);
      start = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 6);
      apply_setup(channels, $urandom_range(0, 7), groups, grouping, start,
                  $urandom_range(0, 1), $urandom_range(0, 4) == 0);
   endtask

   initial begin
      pixel_beat_type got;

      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            got.kind = rsp_kind;
            got.pixel_index = rsp_pixel_index;
            got.red = rsp_red;
            got.green = rsp_green;
            got.blue = rsp_blue;
            got.white = rsp_white;
            got.last = rsp_last;
            book.check_result(got);
         end
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = !calm && ($urandom_range(99) < 7);
         end
      end
   end

   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int budget;
      int pick;
      int len;

      reset = 1'b1;
      req_valid = 1'b0;
      req_slot_value = '0;
      req_first_slot = 1'b0;
      req_last_slot = 1'b0;
      req_do_update = 1'b0;
      req_driver_busy = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Slots before any frame start count from slot zero under the reset settings.
      send_slot(beat(8'h00, 0, 0, 0, 0));
      send_slot(beat(8'hFF, 0, 0, 1, 1));
      send_slot(beat(8'hA5, 0, 0, 0, 1));
      send_slot(beat(8'h3C, 0, 1, 1, 0));
      send_slot(beat(8'h77, 0, 0, 1, 0));
      send_slot(beat(8'h81, 1, 1, 1, 0));
      send_slot(beat(8'h10, 1, 0, 0, 1));
      send_slot(beat(8'h20, 0, 0, 0, 0));
      send_slot(beat(8'h30, 0, 1, 1, 0));
      apply_setup(4, ORDER_RGB, 1, 63, 0, 1, 0);
      send_frame(9, 0, 1, 1, 1);
      apply_setup(3, ORDER_GBR, 170, 1, 5, 1, 1);
      send_frame(24, 0, 1, 1, 1);

      for (int p = 0; p < 10; p++) begin
         case (p)
            0: apply_setup(4, 7, 255, 63, 1023, 0, 1);
            1: apply_setup(0, 0, 0, 0, 0, 0, 0);
            2: apply_setup(3, ORDER_BGR, 170, 2, 1023, 1, 0);
            3: apply_setup(3, ORDER_BRG, 170, 2, 1, 1, 0);
            default: random_setup();
         endcase
         if (p == 3)
            hold_left = 400;
         calm = (p == 5);
         budget = 0;
         while (budget < 15) begin
            pick = $urandom_range(0, 9);
            len = $urandom_range(1, 40);
            if (pick < 8) begin
               send_frame(len, $urandom_range(0, 9) == 0, $urandom_range(0, 3) != 0, 1, 1);
               budget += len;
            end else if (pick == 8) begin
               send_frame($urandom_range(1, 4), 0, 0, 0, 0);
            end else begin
               send_frame(len, 0, 0, 1, 0);
            end
         end
      end
      calm = 0;

      drain();
      repeat (20) @(negedge clock);
      if (book.errors == 0 && book.expected_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/dsm_pkg.sv
rtl/core/dsm_fifo.sv
rtl/core/dsm_front.sv
rtl/core/dsm_back.sv
rtl/core/dmx_slot_to_pixel_mapper.sv
rtl/core/dsm_checker.sv
test/tb.sv
